// ===== rtl/core/nhbw_pkg.sv =====
// Shared types, codes and helpers for the nibble handshake bridge writer.
`default_nettype none

package nhbw_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STATE_W = 3;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;
    localparam int QCNT_W  = 3;

    // Reset value of the retry limit.
    localparam logic [BYTE_W-1:0] RETRIES_RESET = 8'd100;

    // Input command codes.
    localparam logic CMD_START  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Bridge states that the writer waits for.
    localparam logic [STATE_W-1:0] BR_READY = 3'd7;
    localparam logic [STATE_W-1:0] BR_ACK0  = 3'd0;
    localparam logic [STATE_W-1:0] BR_ACK1  = 3'd1;
    localparam logic [STATE_W-1:0] BR_ACK2  = 3'd2;

    // Nibble tags placed in the high half of a driven byte.
    localparam logic [3:0] TAG_ADDR_HI = 4'h3;
    localparam logic [3:0] TAG_ADDR_LO = 4'h0;
    localparam logic [3:0] TAG_DATA_HI = 4'h1;
    localparam logic [3:0] TAG_DATA_LO = 4'h2;

    // Result kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE   = 2'd0,
        KIND_OK      = 2'd1,
        KIND_TIMEOUT = 2'd2
    } kind_t;

    // Write sequence phases.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_SYNC = 3'd1,
        PH_ACK0 = 3'd2,
        PH_ACK1 = 3'd3,
        PH_ACK2 = 3'd4,
        PH_DONE = 3'd5
    } phase_t;

    // One input word.
    typedef struct packed {
        logic              cmd;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] status;
    } item_t;

    // One result word.
    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } result_t;

    // Results of one step: count is 0, 1 or 2.
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } step_t;

    // Bridge state expected while in a phase.
    function automatic logic [STATE_W-1:0] wanted_state(input phase_t ph);
        logic [STATE_W-1:0] st;
        begin
            unique case (ph)
                PH_ACK0: st = BR_ACK0;
                PH_ACK1: st = BR_ACK1;
                PH_ACK2: st = BR_ACK2;
                default: st = BR_READY;
            endcase
            return st;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nhbw_in_if.sv =====
// Input channel interface carrying command and status words.
`default_nettype none

interface nhbw_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [nhbw_pkg::BYTE_W-1:0] address;
    logic [nhbw_pkg::BYTE_W-1:0] data;
    logic [nhbw_pkg::BYTE_W-1:0] status;

    modport source (output valid, cmd, address, data, status, input ready);
    modport sink   (input valid, cmd, address, data, status, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nhbw_out_if.sv =====
// Output channel interface carrying result words.
`default_nettype none

interface nhbw_out_if;
    logic                        valid;
    logic                        ready;
    logic [nhbw_pkg::KIND_W-1:0] kind;
    logic [nhbw_pkg::BYTE_W-1:0] out_byte;
    logic                        last;

    modport source (output valid, kind, out_byte, last, input ready);
    modport sink   (input valid, kind, out_byte, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/nhbw_in_stage.sv =====
// Input register that holds one word until the engine takes it.
`default_nettype none

module nhbw_in_stage
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            up_valid,
    output      logic            up_ready,
    input  wire nhbw_pkg::item_t up_item,
    input  wire logic            take,
    output      logic            item_valid,
    output      nhbw_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    nhbw_pkg::item_t item_reg;

    // The stage refills in the same cycle that its word is taken.
    assign up_ready   = !valid_reg || take;
    assign valid_next = (up_valid && up_ready) || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            item_reg <= up_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ===== rtl/core/nhbw_engine.sv =====
// Write sequencer: phase, retry count and latched operands, one word per step.
`default_nettype none

module nhbw_engine
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        fire,
    input  wire nhbw_pkg::item_t             item,
    input  wire logic [nhbw_pkg::BYTE_W-1:0] max_retries,
    output      nhbw_pkg::step_t             step,
    output      logic                        busy
);

    nhbw_pkg::phase_t            phase_reg;
    nhbw_pkg::phase_t            phase_next;
    logic [nhbw_pkg::BYTE_W-1:0] retry_reg;
    logic [nhbw_pkg::BYTE_W-1:0] retry_next;
    logic [nhbw_pkg::BYTE_W-1:0] addr_reg;
    logic [nhbw_pkg::BYTE_W-1:0] addr_next;
    logic [nhbw_pkg::BYTE_W-1:0] data_reg;
    logic [nhbw_pkg::BYTE_W-1:0] data_next;
    logic [nhbw_pkg::BYTE_W-1:0] nibble;
    logic [nhbw_pkg::BYTE_W-1:0] echo;
    logic                        match;

    assign busy  = (phase_reg != nhbw_pkg::PH_IDLE);
    assign match = (item.status[nhbw_pkg::STATE_W-1:0] == nhbw_pkg::wanted_state(phase_reg));
    assign echo  = {item.status[3:0], 4'h0};

    // Tagged nibble sent when the current wait is satisfied.
    always_comb
    begin
        unique case (phase_reg)
            nhbw_pkg::PH_SYNC: nibble = {nhbw_pkg::TAG_ADDR_HI, addr_reg[7:4]};
            nhbw_pkg::PH_ACK0: nibble = {nhbw_pkg::TAG_ADDR_LO, addr_reg[3:0]};
            nhbw_pkg::PH_ACK1: nibble = {nhbw_pkg::TAG_DATA_HI, data_reg[7:4]};
            default:           nibble = {nhbw_pkg::TAG_DATA_LO, data_reg[3:0]};
        endcase
    end

    // Next state and results of the word in the input register.
    always_comb
    begin
        phase_next = phase_reg;
        retry_next = retry_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        step       = '0;
        step.res0.kind = nhbw_pkg::KIND_WRITE;
        step.res1.kind = nhbw_pkg::KIND_WRITE;
        if (fire)
        begin
            if (item.cmd == nhbw_pkg::CMD_START)
            begin
                if (!busy)
                begin
                    addr_next  = item.address;
                    data_next  = item.data;
                    phase_next = nhbw_pkg::PH_SYNC;
                    retry_next = '0;
                end
            end
            else if (busy)
            begin
                if (match)
                begin
                    retry_next      = '0;
                    step.count      = 2'd1;
                    step.res0.last  = 1'b1;
                    unique case (phase_reg)
                        nhbw_pkg::PH_SYNC: phase_next = nhbw_pkg::PH_ACK0;
                        nhbw_pkg::PH_ACK0: phase_next = nhbw_pkg::PH_ACK1;
                        nhbw_pkg::PH_ACK1: phase_next = nhbw_pkg::PH_ACK2;
                        nhbw_pkg::PH_ACK2: phase_next = nhbw_pkg::PH_DONE;
                        default:           phase_next = nhbw_pkg::PH_IDLE;
                    endcase
                    if (phase_reg == nhbw_pkg::PH_DONE)
                    begin
                        step.res0.kind = nhbw_pkg::KIND_OK;
                    end
                    else
                    begin
                        step.res0.out_byte = nibble;
                    end
                end
                else if (retry_reg >= max_retries)
                begin
                    // Retries used up: echo the sample, then report a timeout.
                    step.count         = 2'd2;
                    step.res0.out_byte = echo;
                    step.res1.kind     = nhbw_pkg::KIND_TIMEOUT;
                    step.res1.last     = 1'b1;
                    phase_next         = nhbw_pkg::PH_IDLE;
                    retry_next         = '0;
                end
                else
                begin
                    step.count         = 2'd1;
                    step.res0.out_byte = echo;
                    step.res0.last     = 1'b1;
                    retry_next         = retry_reg + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= nhbw_pkg::PH_IDLE;
            retry_reg <= '0;
            addr_reg  <= '0;
            data_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            retry_reg <= retry_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nhbw_res_queue.sv =====
// Four-entry result queue that takes up to two words a cycle and gives one.
`default_nettype none

module nhbw_res_queue
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire nhbw_pkg::step_t               push,
    output      logic                          room,
    input  wire logic                          pop,
    output      logic                          res_valid,
    output      nhbw_pkg::result_t             res,
    output      logic [nhbw_pkg::QCNT_W-1:0]   count
);

    nhbw_pkg::result_t             mem [nhbw_pkg::QDEPTH];
    logic [nhbw_pkg::QPTR_W-1:0]   head_reg;
    logic [nhbw_pkg::QPTR_W-1:0]   head_next;
    logic [nhbw_pkg::QPTR_W-1:0]   tail_reg;
    logic [nhbw_pkg::QPTR_W-1:0]   tail_next;
    logic [nhbw_pkg::QCNT_W-1:0]   count_reg;
    logic [nhbw_pkg::QCNT_W-1:0]   count_next;
    logic [nhbw_pkg::QPTR_W-1:0]   tail_plus1;

    assign tail_plus1 = tail_reg + 2'd1;

    // Room for a full step of two words.
    assign room      = (count_reg <= 3'd2);
    assign res_valid = (count_reg != '0);
    assign res       = mem[head_reg];
    assign count     = count_reg;

    // Pointer and fill bookkeeping.
    always_comb
    begin
        head_next  = pop ? head_reg + 2'd1 : head_reg;
        tail_next  = tail_reg + push.count;
        count_next = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // Result storage writes.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[tail_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem[tail_plus1] <= push.res1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/nibble_handshake_bridge_writer_core.sv =====
// Top level of the nibble handshake bridge writer.
// Takes one word per cycle on req: a start word latches address and data, and each
// later word is one sample of the bridge status byte. Every word passes through an
// input register, is handled by the sequencer and lands in a four-entry result queue,
// so a word that causes a result shows it on rsp once it has passed the input register
// and then the result queue. Sustained rate is one word per cycle while rsp is drained
// at one word per cycle; req stalls only when the result queue holds more than two
// words, which the two-word timeout case can cause when rsp is slow. max_retries is
// written through cfg_we/cfg_wdata, resets to 100, and should only be changed while
// idle.
`default_nettype none

module nibble_handshake_bridge_writer_core
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    nhbw_in_if.sink                          req,
    nhbw_out_if.source                       rsp,
    input  wire logic                        cfg_we,
    input  wire logic [nhbw_pkg::BYTE_W-1:0] cfg_wdata
);

    logic [nhbw_pkg::BYTE_W-1:0] max_retries_reg;
    nhbw_pkg::item_t             up_item;
    nhbw_pkg::item_t             item;
    logic                        item_valid;
    logic                        fire;
    logic                        room;
    logic                        busy;
    logic                        pop;
    nhbw_pkg::step_t             step;
    nhbw_pkg::result_t           res;
    logic [nhbw_pkg::QCNT_W-1:0] q_count;

    // Retry limit register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_retries_reg <= nhbw_pkg::RETRIES_RESET;
        end
        else if (cfg_we)
        begin
            max_retries_reg <= cfg_wdata;
        end
    end

    // Pack the input word.
    assign up_item.cmd     = req.cmd;
    assign up_item.address = req.address;
    assign up_item.data    = req.data;
    assign up_item.status  = req.status;

    // A held word steps whenever the queue can take two results.
    assign fire = item_valid && room;
    assign pop  = rsp.valid && rsp.ready;

    nhbw_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (req.valid),
        .up_ready   (req.ready),
        .up_item    (up_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    nhbw_engine u_engine
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .max_retries (max_retries_reg),
        .step        (step),
        .busy        (busy)
    );

    nhbw_res_queue u_res_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .room      (room),
        .pop       (pop),
        .res_valid (rsp.valid),
        .res       (res),
        .count     (q_count)
    );

    // Drive the result word.
    assign rsp.kind     = res.kind;
    assign rsp.out_byte = res.out_byte;
    assign rsp.last     = res.last;

    // A timeout step always leaves the sequencer idle.
    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step.count == 2'd2) |=> !busy)
        else $error("sequencer still busy after a timeout");

    // The sequencer only goes idle on a step that produced a result.
    a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(fire && (step.count != 2'd0)))
        else $error("sequencer went idle without a result");

    // The result queue is never overfilled.
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (step.count != 2'd0) |-> (q_count <= 3'd2))
        else $error("result queue overflow");

endmodule

`default_nettype wire
